// File: rtl/ipv4_payload_word_filter_unit_defines.svh
// Assertion macros used by the filter's checker file.
// No dependencies; the using module must have clk and rst_n in scope.
`ifndef IPV4_PAYLOAD_WORD_FILTER_UNIT_DEFINES_SVH
`define IPV4_PAYLOAD_WORD_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define IPWF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipwf assertion failed");

// Next-cycle implication, disabled while in reset.
`define IPWF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipwf assertion failed");

`endif

// File: rtl/ipwf_pkg.sv
// Types and constants for the IPv4 payload word filter.
// No dependencies.
package ipwf_pkg;

  localparam int OffsetW = 17;
  typedef logic [OffsetW-1:0] offset_t;

  localparam offset_t OffsetMax      = 17'h1FFFF;
  localparam offset_t EtherTypeHiOff = 17'd12;
  localparam offset_t EtherTypeLoOff = 17'd13;
  localparam offset_t IpStart        = 17'd14;
  localparam offset_t TotalLenHiOff  = 17'd16;
  localparam offset_t TotalLenLoOff  = 17'd17;
  localparam offset_t WindowBytes    = 17'd4;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [31:0] PatternReset  = 32'h6675636B;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic drop;
    logic is_ipv4;
  } out_word_t;

  // Verdict handed from the parser to the output queue.
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } push_t;

  // Output queue occupancy, used for input backpressure.
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } q_status_t;

endpackage

// File: rtl/ipwf_parse.sv
// Per-frame header capture and payload window compare.
// Depends on ipwf_pkg.
module ipwf_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  ipwf_pkg::in_word_t item,
  input  logic [31:0]        pattern,
  output ipwf_pkg::push_t    push
);

  ipwf_pkg::offset_t off_r, off_nxt;
  logic [15:0] et_r, et_nxt, et_new;
  logic [5:0]  hb_r, hb_nxt, hb_new;
  logic [15:0] pl_r, pl_nxt, pl_new;
  logic [23:0] recent_r, recent_nxt;
  logic        match_r, match_nxt, match_new;
  logic [31:0] window;
  logic [17:0] first_end;
  logic [17:0] len_end;
  logic        is_v4;
  logic        hit;

  always_comb begin
    et_new = et_r;
    hb_new = hb_r;
    pl_new = pl_r;
    case (off_r)
      ipwf_pkg::EtherTypeHiOff: et_new = {item.frame_byte, 8'h00};
      ipwf_pkg::EtherTypeLoOff: et_new = {et_r[15:8], item.frame_byte};
      ipwf_pkg::IpStart:        hb_new = {item.frame_byte[3:0], 2'b00};
      ipwf_pkg::TotalLenHiOff:  pl_new = {item.frame_byte, 8'h00};
      ipwf_pkg::TotalLenLoOff:  pl_new = {pl_r[15:8], item.frame_byte};
      default: ;
    endcase

    window    = {recent_r, item.frame_byte};
    // last byte of the first payload window, and one past the IP datagram
    first_end = 18'(ipwf_pkg::IpStart) + 18'(ipwf_pkg::WindowBytes) - 18'd1 + 18'(hb_new);
    len_end   = 18'(ipwf_pkg::IpStart) + 18'(pl_new);
    is_v4     = (et_new == ipwf_pkg::EtherTypeIpv4);
    hit       = is_v4 && ({1'b0, off_r} >= first_end) && ({1'b0, off_r} < len_end)
                && (window == pattern);
    match_new = match_r | hit;

    off_nxt    = off_r;
    et_nxt     = et_r;
    hb_nxt     = hb_r;
    pl_nxt     = pl_r;
    recent_nxt = recent_r;
    match_nxt  = match_r;
    if (item_valid) begin
      if (item.last_byte) begin
        off_nxt    = '0;
        et_nxt     = '0;
        hb_nxt     = '0;
        pl_nxt     = '0;
        recent_nxt = '0;
        match_nxt  = 1'b0;
      end else begin
        off_nxt    = (off_r == ipwf_pkg::OffsetMax) ? off_r : off_r + 17'd1;
        et_nxt     = et_new;
        hb_nxt     = hb_new;
        pl_nxt     = pl_new;
        recent_nxt = window[23:0];
        match_nxt  = match_new;
      end
    end

    push.valid        = item_valid && item.last_byte;
    push.word.drop    = is_v4 && match_new;
    push.word.is_ipv4 = is_v4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= '0;
      et_r     <= '0;
      hb_r     <= '0;
      pl_r     <= '0;
      recent_r <= '0;
      match_r  <= 1'b0;
    end else begin
      off_r    <= off_nxt;
      et_r     <= et_nxt;
      hb_r     <= hb_nxt;
      pl_r     <= pl_nxt;
      recent_r <= recent_nxt;
      match_r  <= match_nxt;
    end
  end

endmodule

// File: rtl/ipwf_out_queue.sv
// Two-entry verdict queue: output register plus skid slot.
// Depends on ipwf_pkg.
module ipwf_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ipwf_pkg::push_t      push,
  input  logic                 out_stall,
  output logic                 out_valid,
  output ipwf_pkg::out_word_t  out_payload,
  output ipwf_pkg::q_status_t  status
);

  ipwf_pkg::out_word_t q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] slot;
  logic       pop;

  always_comb begin
    pop    = (cnt_r != 2'd0) && !out_stall;
    slot   = cnt_r - 2'(pop);
    q0_nxt = q0_r;
    q1_nxt = q1_r;
    if (pop) begin
      q0_nxt = q1_r;
    end
    if (push.valid) begin
      if (slot == 2'd0) begin
        q0_nxt = push.word;
      end else begin
        q1_nxt = push.word;
      end
    end
    cnt_nxt = cnt_r + 2'(push.valid) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_valid    = (cnt_r != 2'd0);
  assign out_payload  = q0_r;
  assign status.count = cnt_r;
  assign status.pop   = pop;

endmodule

// File: rtl/ipv4_payload_word_filter_unit.sv
// IPv4 payload word filter, top level.
// Depends on ipwf_pkg, ipwf_parse and ipwf_out_queue.
//
// Takes one Ethernet frame byte per clock while in_stall is low, destination
// address first, with last_byte on the final byte, and gives one verdict word
// per frame: is_ipv4 when the EtherType is 0x0800, and drop when an IPv4 frame
// carried the 32-bit cfg pattern in a 4-byte window lying wholly inside the IP
// payload (past the IHL header, before the IP total length runs out). Frames
// whose lengths are too short for a window never match; frames shorter than
// their total length are only checked over the bytes received. The block
// accepts one byte every clock while in_stall is low. The verdict passes the
// input register, then parse and compare push it into the output queue, whose
// register drives out_valid. in_stall rises when the two-entry output queue is
// about to hold two verdicts, which needs the verdict consumer to hold
// out_stall across back-to-back frame ends.
// The pattern register is written with cfg_wr_en and should change only
// while no frame is in flight.
module ipv4_payload_word_filter_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ipwf_pkg::in_word_t  in_payload,
  output logic                out_valid,
  input  logic                out_stall,
  output ipwf_pkg::out_word_t out_payload,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);

  logic                in_accept;
  logic                in_v_r;
  ipwf_pkg::in_word_t  in_r;
  logic [31:0]         pattern_r;
  ipwf_pkg::push_t     push;
  ipwf_pkg::q_status_t q_status;
  logic [2:0]          pending;

  // Words already owed to the queue: stored verdicts plus a frame end
  // sitting in the input register, less the one leaving this cycle.
  assign pending   = 3'(q_status.count) + 3'(in_v_r & in_r.last_byte) - 3'(q_status.pop);
  assign in_stall  = (pending > 3'd1);
  assign in_accept = in_valid && !in_stall;

  // input register: every accepted word is processed on the next clock
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_payload;
    end
  end

  // match pattern, first payload byte in the top bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= ipwf_pkg::PatternReset;
    end else if (cfg_wr_en) begin
      pattern_r <= cfg_wr_data;
    end
  end

  ipwf_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_v_r),
    .item       (in_r),
    .pattern    (pattern_r),
    .push       (push)
  );

  ipwf_out_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_payload (out_payload),
    .status      (q_status)
  );

endmodule

// File: rtl/ipwf_checker.sv
// Port-level checks for the IPv4 payload word filter, bound to the top.
// Depends on ipwf_pkg and ipv4_payload_word_filter_unit_defines.svh.
`include "ipv4_payload_word_filter_unit_defines.svh"

module ipwf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input ipwf_pkg::in_word_t  in_payload,
  input logic                out_valid,
  input logic                out_stall,
  input ipwf_pkg::out_word_t out_payload
);

  // a held verdict stays offered
  `IPWF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // drop is only given for IPv4 frames
  `IPWF_ASSERT_NOW(a_drop_v4, out_valid, !out_payload.drop || out_payload.is_ipv4)

  // a frame end accepted shows a verdict once it has passed the input register and the output queue
  `IPWF_ASSERT_NEXT(a_end_verdict, in_valid && !in_stall && in_payload.last_byte, ##1 out_valid)

  // backpressure only arises from a waiting verdict
  `IPWF_ASSERT_NOW(a_stall_cause, in_stall, out_valid)

endmodule

bind ipv4_payload_word_filter_unit ipwf_checker u_ipwf_checker (.*);
